// ===== hdl/assert_macros.svh =====
// Concurrent check macros; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PBA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PBA_ASSERT_IMPLY(lbl, ante, cons, msg)

`define PBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hdl/pba_pkg.sv =====
package pba_pkg;

  localparam int PAGE_W        = 12;
  localparam int COUNT_W       = 13;
  localparam int COUNT_MAX     = (1 << COUNT_W) - 1;
  localparam int PAGE_SPACE    = 1 << PAGE_W;
  localparam int WORD_MAX      = 64;
  localparam int MAX_PAGES_DEF = 4096;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_MARK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND,
    S_WRITE
  } state_t;

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
    return (v == COUNT_W'(COUNT_MAX)) ? v : v + COUNT_W'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] count_down(input logic [COUNT_W-1:0] v);
    return (v == '0) ? v : v - COUNT_W'(1);
  endfunction

endpackage

// ===== hdl/pba_req_if.sv =====
interface pba_req_if;
  logic                       valid;
  logic                       ready;
  pba_pkg::op_t               operation;
  logic [pba_pkg::PAGE_W-1:0] page;

  modport source (output valid, output operation, output page, input ready);
  modport sink   (input valid, input operation, input page, output ready);
endinterface

// ===== hdl/pba_rsp_if.sv =====
interface pba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pba_pkg::PAGE_W-1:0]  granted_page;
  logic                        ok;
  logic [pba_pkg::COUNT_W-1:0] free_count;
  logic [pba_pkg::COUNT_W-1:0] total_count;

  modport source (output valid, output granted_page, output ok, output free_count,
                  output total_count, input ready);
  modport sink   (input valid, input granted_page, input ok, input free_count,
                  input total_count, output ready);
endinterface

// ===== hdl/pba_find_first.sv =====
module pba_find_first #(
  parameter int W     = 64,
  parameter int IDX_W = 6
) (
  input  logic [W-1:0]     vec,
  output logic [IDX_W-1:0] idx,
  output logic             found
);

  // lowest set bit wins
  always_comb begin
    idx   = '0;
    found = |vec;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== hdl/pba_map_ram.sv =====
module pba_map_ram #(
  parameter int WORDS  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_r;
  logic [WORDS-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  // a word never written reads as all reserved
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (en && we) begin
        vld_r[addr] <= 1'b1;
      end
      if (en && !we) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign rdata = rd_vld_r ? rdata_r : '1;

endmodule

// ===== hdl/page_bitmap_allocator.sv =====
// Page frame allocator over a one-bit-per-page map (1 = reserved or in use).
// in_req carries one operation per beat: alloc, free, reserve or mark_usable,
// with a page index. out_rsp returns one beat per operation: the granted page
// (alloc only), ok when the map changed, and the free and usable page counts.
// cfg_we/cfg_data write the page limit; write it only while the block is idle.
// The result is registered at write-back, after the read and find states; a new
// beat is taken only once the previous one has written back. Each operation is one
// read-modify-write of a 64-page map word: read, search the word, write back.
// alloc picks its word from a register of per-word "has a free page" flags,
// so the search adds no state to the sequence whatever the fill of the map.
// Reset marks every page reserved through per-word valid flags, so no
// clearing pass is needed; both counts go to zero and the limit to 4096.
// If out_rsp stalls, a finished result holds in the output register; the
// next beat is still taken and its work holds before write-back until the
// output register frees.
`include "assert_macros.svh"

module page_bitmap_allocator #(
  parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pba_pkg::COUNT_W-1:0] cfg_data,
  pba_req_if.sink                     in_req,
  pba_rsp_if.source                   out_rsp
);

  import pba_pkg::*;

  // pages above the input index space can never be freed, so they are not stored
  localparam int SPAN    = (MAX_PAGES < PAGE_SPACE) ? MAX_PAGES : PAGE_SPACE;
  localparam int WORD_W  = (SPAN >= WORD_MAX) ? WORD_MAX : (1 << ($clog2(SPAN + 1) - 1));
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int NWORDS  = (SPAN + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LIM_CAP = (MAX_PAGES < COUNT_MAX) ? MAX_PAGES : COUNT_MAX;

  state_t               state_r, state_nxt;
  op_t                  op_r;
  logic [PAGE_W-1:0]    page_r;
  logic [COUNT_W-1:0]   page_limit_r;
  logic [COUNT_W-1:0]   lim;
  logic [COUNT_W-1:0]   lim_word;
  logic [COUNT_W-1:0]   free_r;
  logic [COUNT_W-1:0]   total_r;
  logic [WADDR_W-1:0]   word_r, word_sel, sum_idx, ram_addr;
  logic [BIT_W-1:0]     bit_r, bit_nxt, cand_idx, pg_bit;
  logic [NWORDS-1:0]    sum_r;
  logic [WORD_W-1:0]    rd_word, wr_word, cand, lim_mask, clr_mask, onehot;
  logic                 sum_any, sum_found_r, cand_any;
  logic                 act_r, act_nxt;
  logic                 cur, in_rng, set_bit, advance;
  logic                 ram_en, ram_we;
  logic                 out_valid_r, ok_r;
  logic [PAGE_W-1:0]    grant_r;

  assign lim = (page_limit_r < COUNT_W'(LIM_CAP)) ? page_limit_r : COUNT_W'(LIM_CAP);

  assign in_req.ready = (state_r == S_IDLE);
  assign advance      = !out_valid_r || out_rsp.ready;

  pba_find_first #(.W(NWORDS), .IDX_W(WADDR_W)) u_word_find (
    .vec   (sum_r),
    .idx   (sum_idx),
    .found (sum_any)
  );

  pba_find_first #(.W(WORD_W), .IDX_W(BIT_W)) u_bit_find (
    .vec   (cand),
    .idx   (cand_idx),
    .found (cand_any)
  );

  pba_map_ram #(.WORDS(NWORDS), .WIDTH(WORD_W), .ADDR_W(WADDR_W)) u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_word),
    .rdata (rd_word)
  );

  assign word_sel = (op_r == OP_ALLOC) ? sum_idx : page_r[BIT_W +: WADDR_W];

  always_comb begin
    state_nxt = state_r;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = word_r;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ram_en    = 1'b1;
        ram_addr  = word_sel;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (advance) begin
          ram_en    = act_r;
          ram_we    = act_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // mask off page zero and pages at or above the limit within the word
  assign lim_word = lim >> BIT_W;

  always_comb begin
    clr_mask = '1;
    if (word_r == '0) begin
      clr_mask[0] = 1'b0;
    end
    for (int b = 0; b < WORD_W; b++) begin
      lim_mask[b] = (lim_word > COUNT_W'(word_r)) ||
                    ((lim_word == COUNT_W'(word_r)) && (BIT_W'(b) < lim[BIT_W-1:0]));
    end
  end

  assign cand   = ~rd_word & clr_mask & lim_mask;
  assign pg_bit = page_r[BIT_W-1:0];
  assign cur    = rd_word[pg_bit];
  assign in_rng = COUNT_W'(page_r) < lim;

  always_comb begin
    bit_nxt = pg_bit;
    case (op_r)
      OP_ALLOC: begin
        act_nxt = sum_found_r && cand_any;
        bit_nxt = cand_idx;
      end
      OP_FREE:    act_nxt = in_rng && (page_r != '0) && cur;
      OP_RESERVE: act_nxt = in_rng && !cur;
      OP_MARK:    act_nxt = in_rng && cur;
      default:    act_nxt = 1'b0;
    endcase
  end

  assign set_bit = (op_r == OP_ALLOC) || (op_r == OP_RESERVE);
  assign onehot  = WORD_W'(1) << bit_r;
  assign wr_word = set_bit ? (rd_word | onehot) : (rd_word & ~onehot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      op_r   <= in_req.operation;
      page_r <= in_req.page;
    end
    if (state_r == S_READ) begin
      word_r      <= word_sel;
      sum_found_r <= sum_any;
    end
    if (state_r == S_FIND) begin
      bit_r <= bit_nxt;
      act_r <= act_nxt;
    end
    if (state_r == S_WRITE && advance) begin
      ok_r    <= act_r;
      grant_r <= (op_r == OP_ALLOC && act_r) ? PAGE_W'({word_r, bit_r}) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      page_limit_r <= cfg_data;
    end
  end

  // counts and word flags change only at write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '0;
      total_r <= '0;
      sum_r   <= '0;
    end else if (state_r == S_WRITE && advance && act_r) begin
      sum_r[word_r] <= |(~wr_word & clr_mask);
      if (set_bit) begin
        free_r <= count_down(free_r);
      end else begin
        free_r <= count_up(free_r);
      end
      if (op_r == OP_MARK) begin
        total_r <= count_up(total_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_WRITE && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.granted_page = grant_r;
  assign out_rsp.ok           = ok_r;
  assign out_rsp.free_count   = free_r;
  assign out_rsp.total_count  = total_r;

  `PBA_ASSERT_IMPLY(a_no_page_zero, state_r == S_WRITE && op_r == OP_ALLOC && act_r, (word_r != '0) || (bit_r != '0), "alloc grants page zero")
  `PBA_ASSERT_NEXT(a_counts_hold, state_r != S_WRITE, $stable(free_r) && $stable(total_r), "counts move outside write-back")
  `PBA_ASSERT_IMPLY(a_out_from_write, $rose(out_valid_r), $past(state_r) == S_WRITE, "result without write-back")
  `PBA_ASSERT_NEXT(a_stall_holds, state_r == S_WRITE && out_valid_r && !out_rsp.ready, state_r == S_WRITE, "write-back passes a full output register")

endmodule
